// ===== rtl/ipv4p_pkg.sv =====
// Shared types and character constants for the IPv4 address and port string parser.
`timescale 1ns / 1ps

package ipv4p_pkg;

  // Number base of the part being parsed.
  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  // One result word.
  typedef struct packed {
    logic        status;
    logic        address_valid;
    logic [31:0] address;
    logic        port_valid;
    logic [15:0] port_value;
  } result_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

endpackage

// ===== rtl/ipv4_address_port_string_parser.sv =====
// Top level of the IPv4 address and port string parser (one character per word).
`timescale 1ns / 1ps
// Throughput: one character word per cycle while in_stall is low; each is consumed when taken.
// The result word for a terminating zero byte is registered (skid slot if the output stalls).
// The rate is set by the single parse step (a radix multiply-add and its limit checks) that sits
// between the parse state registers and the result register; a skid register absorbs one stall.
// Reset (rst, synchronous, active high) clears the parse state, strict and both result valid flags.

module ipv4_address_port_string_parser (
  input  logic        clk,
  input  logic        rst,
  // Character input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  // Result output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic        address_valid,
  output logic [31:0] address,
  output logic        port_valid,
  output logic [15:0] port_value,
  // Configuration write channel for the strict_mode register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        strict_mode
);

  // Parse phase. After an error the block skips to the zero byte; the two skip
  // phases remember whether the address had already been committed.
  typedef enum logic [1:0] {
    PH_ADDR,
    PH_PORT,
    PH_SKIP_ADDR,
    PH_SKIP_PORT
  } phase_t;

  // Outcome of offering one character to the number being parsed.
  typedef enum logic [1:0] {
    NC_TAKEN,
    NC_END,
    NC_ERR
  } nc_t;

  // Configuration register.
  logic strict;

  // Parse state.
  phase_t             phase;
  logic [1:0]         part_count;
  logic [7:0]         earlier_parts [3];
  logic [31:0]        current_value;
  logic [1:0]         digit_count;
  ipv4p_pkg::radix_t  number_radix;
  logic               leading_zero;
  logic [31:0]        committed_address;

  phase_t             phase_next;
  logic [1:0]         part_count_next;
  logic [7:0]         earlier_parts_next [3];
  logic [31:0]        current_value_next;
  logic [1:0]         digit_count_next;
  ipv4p_pkg::radix_t  number_radix_next;
  logic               leading_zero_next;
  logic [31:0]        committed_address_next;

  // Output register and skid register.
  ipv4p_pkg::result_t out_word;
  ipv4p_pkg::result_t skid_word;
  logic               skid_valid;

  // Combinational step values.
  logic               in_take;
  logic               out_taken;
  logic               emit;
  ipv4p_pkg::result_t result;

  logic               is_x;
  logic               is_09;
  logic               is_hex_letter;
  logic               allow_prefix;
  logic [4:0]         radix_value;
  logic [3:0]         digit;
  logic [35:0]        product;
  logic [35:0]        sum;

  nc_t                nc_kind;
  logic [31:0]        nc_value;
  logic [1:0]         nc_digit_count;
  ipv4p_pkg::radix_t  nc_radix;
  logic               nc_leading_zero;

  logic               end_fail;
  logic               dot_fail;
  logic               limit_over;
  logic               last_fail;
  logic               port_ok;
  logic [31:0]        assembled;

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = skid_valid;
  assign out_taken = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  assign status        = out_word.status;
  assign address_valid = out_word.address_valid;
  assign address       = out_word.address;
  assign port_valid    = out_word.port_valid;
  assign port_value    = out_word.port_value;

  // Offer the character to the number being built.
  always_comb begin
    is_x  = (character == ipv4p_pkg::CH_LX) || (character == ipv4p_pkg::CH_UX);
    is_09 = (character >= ipv4p_pkg::CH_ZERO) && (character <= ipv4p_pkg::CH_NINE);
    is_hex_letter = ((character >= ipv4p_pkg::CH_LA) && (character <= ipv4p_pkg::CH_LF)) ||
                    ((character >= ipv4p_pkg::CH_UA) && (character <= ipv4p_pkg::CH_UF));
    allow_prefix = (phase == PH_PORT) || !strict;

    // Both cases of a hex letter share a low nibble; adding 9 to it gives the letter's value.
    digit = is_09 ? character[3:0] : character[3:0] + 4'd9;

    unique case (number_radix)
      ipv4p_pkg::RX_OCT: begin
        radix_value = 5'd8;
        product     = {1'b0, current_value, 3'b000};
      end
      ipv4p_pkg::RX_HEX: begin
        radix_value = 5'd16;
        product     = {current_value, 4'b0000};
      end
      default: begin
        radix_value = 5'd10;
        product     = {1'b0, current_value, 3'b000} + {3'b000, current_value, 1'b0};
      end
    endcase
    sum = product + {32'd0, digit};

    nc_value        = current_value;
    nc_digit_count  = digit_count;
    nc_radix        = number_radix;
    nc_leading_zero = leading_zero;

    if ((number_radix == ipv4p_pkg::RX_OCT) && (digit_count == 2'd1) && is_x) begin
      // A lone leading zero followed by x switches to hex.
      nc_kind        = NC_TAKEN;
      nc_radix       = ipv4p_pkg::RX_HEX;
      nc_digit_count = 2'd0;
      nc_value       = 32'd0;
    end else if (allow_prefix && (number_radix == ipv4p_pkg::RX_DEC) &&
                 (digit_count == 2'd0) && (character == ipv4p_pkg::CH_ZERO)) begin
      nc_kind         = NC_TAKEN;
      nc_radix        = ipv4p_pkg::RX_OCT;
      nc_digit_count  = 2'd1;
      nc_value        = 32'd0;
      nc_leading_zero = 1'b1;
    end else if (!(is_09 || ((number_radix == ipv4p_pkg::RX_HEX) && is_hex_letter))) begin
      nc_kind = NC_END;
    end else if ({1'b0, digit} >= radix_value) begin
      // An 8 or 9 right after a lone octal zero is an error.
      nc_kind = ((number_radix == ipv4p_pkg::RX_OCT) && (digit_count == 2'd1)) ? NC_ERR : NC_END;
    end else begin
      if ((number_radix == ipv4p_pkg::RX_DEC) && (digit_count == 2'd0) &&
          (character == ipv4p_pkg::CH_ZERO)) begin
        nc_leading_zero = 1'b1;
      end
      nc_value       = sum[31:0];
      nc_digit_count = (digit_count == 2'd3) ? 2'd3 : digit_count + 2'd1;
      nc_kind        = (|sum[35:32]) ? NC_ERR : NC_TAKEN;
    end
  end

  // Checks made when a number ends, and the address it would commit.
  always_comb begin
    end_fail = (strict && (digit_count == 2'd1) && leading_zero && is_x) ||
               (digit_count == 2'd0) ||
               (strict && leading_zero && (digit_count > 2'd1));
    dot_fail = (part_count == 2'd3) || (|current_value[31:8]);

    // The last part has to fit the bytes the earlier parts leave free.
    unique case (part_count)
      2'd0:    limit_over = 1'b0;
      2'd1:    limit_over = |current_value[31:24];
      2'd2:    limit_over = |current_value[31:16];
      default: limit_over = |current_value[31:8];
    endcase
    last_fail = limit_over || (strict && (part_count != 2'd3));

    assembled = current_value;
    if (part_count > 2'd0) assembled = assembled | {earlier_parts[0], 24'd0};
    if (part_count > 2'd1) assembled = assembled | {8'd0, earlier_parts[1], 16'd0};
    if (part_count > 2'd2) assembled = assembled | {16'd0, earlier_parts[2], 8'd0};

    port_ok = (digit_count != 2'd0) &&
              !((number_radix == ipv4p_pkg::RX_OCT) && (digit_count == 2'd1)) &&
              !(|current_value[31:16]);
  end

  // Next parse state and the result word for a terminating zero byte.
  always_comb begin
    phase_next             = phase;
    part_count_next        = part_count;
    earlier_parts_next     = earlier_parts;
    current_value_next     = current_value;
    digit_count_next       = digit_count;
    number_radix_next      = number_radix;
    leading_zero_next      = leading_zero;
    committed_address_next = committed_address;
    emit                   = 1'b0;
    result                 = '0;
    result.status          = ipv4p_pkg::STATUS_INVALID;

    if (in_take && (character != ipv4p_pkg::CH_NUL)) begin
      unique case (phase)
        PH_ADDR: begin
          if (nc_kind == NC_TAKEN) begin
            current_value_next = nc_value;
            digit_count_next   = nc_digit_count;
            number_radix_next  = nc_radix;
            leading_zero_next  = nc_leading_zero;
          end else if ((nc_kind == NC_ERR) || end_fail) begin
            phase_next = PH_SKIP_ADDR;
          end else if (character == ipv4p_pkg::CH_DOT) begin
            if (dot_fail) begin
              phase_next = PH_SKIP_ADDR;
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (part_count == 2'(i)) earlier_parts_next[i] = current_value[7:0];
              end
              part_count_next    = part_count + 2'd1;
              current_value_next = 32'd0;
              digit_count_next   = 2'd0;
              number_radix_next  = ipv4p_pkg::RX_DEC;
              leading_zero_next  = 1'b0;
            end
          end else if (last_fail) begin
            phase_next = PH_SKIP_ADDR;
          end else begin
            // The address is complete; anything but a colon after it fails the port.
            committed_address_next = assembled;
            if (character == ipv4p_pkg::CH_COLON) begin
              phase_next         = PH_PORT;
              current_value_next = 32'd0;
              digit_count_next   = 2'd0;
              number_radix_next  = ipv4p_pkg::RX_DEC;
              leading_zero_next  = 1'b0;
            end else begin
              phase_next = PH_SKIP_PORT;
            end
          end
        end
        PH_PORT: begin
          if (nc_kind == NC_TAKEN) begin
            current_value_next = nc_value;
            digit_count_next   = nc_digit_count;
            number_radix_next  = nc_radix;
            leading_zero_next  = nc_leading_zero;
          end else begin
            phase_next = PH_SKIP_PORT;
          end
        end
        default: begin
        end
      endcase
    end else if (in_take) begin
      emit = 1'b1;
      unique case (phase)
        PH_ADDR: begin
          if (!end_fail && !last_fail) begin
            result.status        = ipv4p_pkg::STATUS_OK;
            result.address_valid = 1'b1;
            result.address       = assembled;
            result.port_valid    = 1'b1;
          end
        end
        PH_PORT: begin
          result.address_valid = 1'b1;
          result.address       = committed_address;
          if (port_ok) begin
            result.status     = ipv4p_pkg::STATUS_OK;
            result.port_valid = 1'b1;
            result.port_value = {current_value[7:0], current_value[15:8]};
          end
        end
        PH_SKIP_PORT: begin
          result.address_valid = 1'b1;
          result.address       = committed_address;
        end
        default: begin
        end
      endcase

      // The zero byte returns the parse state to its reset value.
      phase_next             = PH_ADDR;
      part_count_next        = 2'd0;
      earlier_parts_next     = '{default: 8'd0};
      current_value_next     = 32'd0;
      digit_count_next       = 2'd0;
      number_radix_next      = ipv4p_pkg::RX_DEC;
      leading_zero_next      = 1'b0;
      committed_address_next = 32'd0;
    end
  end

  // Parse state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strict            <= 1'b0;
      phase             <= PH_ADDR;
      part_count        <= 2'd0;
      earlier_parts     <= '{default: 8'd0};
      current_value     <= 32'd0;
      digit_count       <= 2'd0;
      number_radix      <= ipv4p_pkg::RX_DEC;
      leading_zero      <= 1'b0;
      committed_address <= 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) strict <= strict_mode;
      phase             <= phase_next;
      part_count        <= part_count_next;
      earlier_parts     <= earlier_parts_next;
      current_value     <= current_value_next;
      digit_count       <= digit_count_next;
      number_radix      <= number_radix_next;
      leading_zero      <= leading_zero_next;
      committed_address <= committed_address_next;
    end
  end

  // Result register with one skid slot. The input stalls only while the skid slot
  // is full, so a result is never dropped when the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_taken) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= emit;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_taken) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= result;
      end else begin
        out_word <= result;
      end
    end else if (emit) begin
      skid_word <= result;
    end
  end

endmodule
